[src/structured_mesh_connectivity_top_macros.svh]
// Assertion macros shared by the mesh connectivity block.
`ifndef STRUCTURED_MESH_CONNECTIVITY_TOP_MACROS_SVH
`define STRUCTURED_MESH_CONNECTIVITY_TOP_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define SMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define SMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/smc_pkg.sv]
// Types and constants of the structured mesh connectivity block.
package smc_pkg;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 10;
    localparam int NEX_W   = 11;
    localparam int ELEM_W  = 21;
    localparam int NODE_W  = 23;
    localparam int CNT_W   = 4;
    localparam int NODES   = 9;

    // Mesh layouts; the unused code falls back to the bilinear quad.
    localparam logic [2:0] KIND_LINE1 = 3'd0;
    localparam logic [2:0] KIND_LINE2 = 3'd1;
    localparam logic [2:0] KIND_LINE3 = 3'd2;
    localparam logic [2:0] KIND_QUAD1 = 3'd3;
    localparam logic [2:0] KIND_QUAD2 = 3'd4;
    localparam logic [2:0] KIND_SEREN = 3'd5;
    localparam logic [2:0] KIND_TRI   = 3'd6;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MESH_KIND  = 2'd0;
    localparam logic [1:0] REG_ELEMENTS_X = 2'd1;
    localparam logic [1:0] REG_ELEMENTS_Y = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]              count;
        logic [NODES-1:0][NODE_W-1:0]  node;
        logic [ELEM_W-1:0]             elem;
    } t_result;

endpackage

[src/structured_mesh_connectivity_top.sv]
// Top level of the structured mesh connectivity block.
//
// Each request on the slave stream carries an element column and row; the
// master stream returns the element number and its node indices, one result
// per element, or two back-to-back results for the triangle layout, with
// tlast on the final one. The APB port sets the layout and mesh size and must
// be written only while the block is idle; the block itself does not enforce this.
//
// A request is captured in an input register; the node arithmetic (two small
// multipliers and a few adders) sits between it and the output register that
// drives the master stream. A request passes the one shared node-arithmetic
// stage for each result it yields, and a new request can be accepted as the
// final result of the one before it moves to the output register.
// The input side stays ready while a result waits, as long as the input
// register is free; when the receiver stalls, the output holds and the input
// register fills, after which s_axis_tready drops.
// Reset clears both valid flags and loads the bilinear quad layout with a
// one-element mesh.
`include "structured_mesh_connectivity_top_macros.svh"

module structured_mesh_connectivity_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [23:0]   s_axis_tdata,   // column, row
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // element_number, node_a .. node_i, node_count
    output logic [231:0]  m_axis_tdata,
    output logic          m_axis_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [2:0]                  r_kind;
    logic [smc_pkg::NEX_W-1:0]   r_nex;
    logic [smc_pkg::NEX_W-1:0]   r_ney;
    logic                        r_in_vld;
    logic [smc_pkg::COL_W-1:0]   r_col;
    logic [smc_pkg::ROW_W-1:0]   r_row;
    logic                        r_phase;
    logic                        r_out_vld;
    logic                        r_out_last;
    smc_pkg::t_result            r_out;
    smc_pkg::t_result            n_out;

    logic adv;
    logic step;
    logic fin;
    logic s_acc;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= smc_pkg::KIND_QUAD1;
            r_nex  <= 11'd1;
            r_ney  <= 11'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                smc_pkg::REG_MESH_KIND:  r_kind <= pwdata[2:0];
                smc_pkg::REG_ELEMENTS_X: r_nex  <= pwdata[10:0];
                smc_pkg::REG_ELEMENTS_Y: r_ney  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            smc_pkg::REG_MESH_KIND:  prdata = {29'b0, r_kind};
            smc_pkg::REG_ELEMENTS_X: prdata = {21'b0, r_nex};
            smc_pkg::REG_ELEMENTS_Y: prdata = {21'b0, r_ney};
            default:                 prdata = '0;
        endcase
    end

    // The input register frees up when its final result moves to the output.
    assign adv   = !r_out_vld || m_axis_tready;
    assign step  = r_in_vld && adv;
    assign fin   = step && (r_kind != smc_pkg::KIND_TRI || r_phase);
    assign s_axis_tready = !r_in_vld || fin;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    smc_calc u_calc (
        .i_kind  (r_kind),
        .i_nex   (r_nex),
        .i_col   (r_col),
        .i_row   (r_row),
        .i_phase (r_phase),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_phase   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_acc) begin
                r_in_vld <= 1'b1;
            end else if (fin) begin
                r_in_vld <= 1'b0;
            end
            if (step) begin
                r_phase   <= (r_kind == smc_pkg::KIND_TRI) && !r_phase;
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_col <= s_axis_tdata[9:0];
            r_row <= s_axis_tdata[19:10];
        end
        if (step) begin
            r_out      <= n_out;
            r_out_last <= fin;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;
    assign m_axis_tlast  = r_out_last;

    // A first triangle always has three nodes.
    `SMC_ASSERT_NOW(a_tri_count, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[231:228] == 4'd3, "first triangle without three nodes")
    // The second triangle follows at once and numbers one above the first.
    `SMC_ASSERT_NEXT(a_tri_pair, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tlast && m_axis_tdata[20:0] == $past(m_axis_tdata[20:0]) + 21'd1, "second triangle missing or misnumbered")
    // The ninth slot is zero unless all nine nodes are used.
    `SMC_ASSERT_NOW(a_unused_zero, m_axis_tvalid && m_axis_tdata[231:228] != 4'd9, m_axis_tdata[227:205] == 23'd0, "unused node slot not zero")

endmodule

[src/smc_calc.sv]
// Element number and node indices of one mesh element.
module smc_calc (
    input  logic [2:0]                  i_kind,
    input  logic [smc_pkg::NEX_W-1:0]   i_nex,
    input  logic [smc_pkg::COL_W-1:0]   i_col,
    input  logic [smc_pkg::ROW_W-1:0]   i_row,
    input  logic                        i_phase,
    output smc_pkg::t_result            o_res
);

    logic [20:0] cell_num;
    logic [12:0] mult;
    logic [22:0] rs;
    logic [22:0] nx;
    logic [22:0] col1;
    logic [22:0] col2;
    logic [22:0] sw;
    logic [22:0] swn;
    logic [22:0] sw2n;
    logic [22:0] ww;
    logic [22:0] nw;
    logic [22:0] lb;

    assign cell_num = {11'b0, i_row} * {10'b0, i_nex} + {11'b0, i_col};
    assign col1 = {13'b0, i_col};
    assign col2 = {12'b0, i_col, 1'b0};

    // Row stride of the node grid for each layout.
    always_comb begin
        unique case (i_kind)
            smc_pkg::KIND_QUAD2: mult = {i_nex, 2'b00} + 13'd2;
            smc_pkg::KIND_SEREN: mult = {2'b0, i_nex} + {1'b0, i_nex, 1'b0} + 13'd2;
            default:             mult = {2'b0, i_nex} + 13'd1;
        endcase
    end

    assign rs = {13'b0, i_row} * {10'b0, mult};

    assign nx = (i_kind == smc_pkg::KIND_QUAD2 || i_kind == smc_pkg::KIND_SEREN)
              ? {11'b0, i_nex, 1'b1} : {12'b0, i_nex} + 23'd1;
    assign sw = ((i_kind == smc_pkg::KIND_QUAD2 || i_kind == smc_pkg::KIND_SEREN)
              ? col2 : col1) + rs;
    assign swn  = sw + nx;
    assign sw2n = swn + nx;
    assign ww   = col1 + rs + nx;
    assign nw   = sw + {10'b0, mult};

    always_comb begin
        unique case (i_kind)
            smc_pkg::KIND_LINE1: lb = col1;
            smc_pkg::KIND_LINE2: lb = col2;
            default:             lb = col1 + col2;
        endcase
    end

    always_comb begin
        o_res       = '0;
        o_res.elem  = cell_num;
        unique case (i_kind)
            smc_pkg::KIND_LINE1, smc_pkg::KIND_LINE2, smc_pkg::KIND_LINE3: begin
                o_res.elem    = {11'b0, i_col};
                o_res.node[0] = lb;
                o_res.node[1] = lb + 23'd1;
                o_res.node[2] = lb + 23'd2;
                o_res.node[3] = lb + 23'd3;
                // Slots beyond the element's degree stay zero.
                if (i_kind == smc_pkg::KIND_LINE1) begin
                    o_res.node[2] = '0;
                    o_res.node[3] = '0;
                    o_res.count   = 4'd2;
                end else if (i_kind == smc_pkg::KIND_LINE2) begin
                    o_res.node[3] = '0;
                    o_res.count   = 4'd3;
                end else begin
                    o_res.count   = 4'd4;
                end
            end
            smc_pkg::KIND_QUAD2: begin
                o_res.node[0] = sw;
                o_res.node[1] = sw + 23'd1;
                o_res.node[2] = sw + 23'd2;
                o_res.node[3] = swn + 23'd2;
                o_res.node[4] = sw2n + 23'd2;
                o_res.node[5] = sw2n + 23'd1;
                o_res.node[6] = sw2n;
                o_res.node[7] = swn;
                o_res.node[8] = swn + 23'd1;
                o_res.count   = 4'd9;
            end
            smc_pkg::KIND_SEREN: begin
                o_res.node[0] = sw;
                o_res.node[1] = sw + 23'd1;
                o_res.node[2] = sw + 23'd2;
                o_res.node[3] = ww + 23'd1;
                o_res.node[4] = nw + 23'd2;
                o_res.node[5] = nw + 23'd1;
                o_res.node[6] = nw;
                o_res.node[7] = ww;
                o_res.count   = 4'd8;
            end
            smc_pkg::KIND_TRI: begin
                // Two triangles per cell, split along the south-east diagonal.
                o_res.elem    = {cell_num[19:0], i_phase};
                o_res.node[0] = i_phase ? swn : sw;
                o_res.node[1] = sw + 23'd1;
                o_res.node[2] = i_phase ? swn + 23'd1 : swn;
                o_res.count   = 4'd3;
            end
            default: begin
                o_res.node[0] = sw;
                o_res.node[1] = sw + 23'd1;
                o_res.node[2] = swn + 23'd1;
                o_res.node[3] = swn;
                o_res.count   = 4'd4;
            end
        endcase
    end

endmodule
